>>> src/cbk_pkg.sv
// Shared widths and fixed-point constants for the cubic B-spline kernel core.
// No dependencies; the interfaces and the core import it.
`timescale 1ns / 1ps

package cbk_pkg;

  localparam int ARG_W   = 16;   // Q4.12 argument
  localparam int VAL_W   = 15;   // Q1.14 value
  localparam int SLOPE_W = 16;   // Q2.14 slope

  localparam int ABS_W   = 16;   // |x| up to 8.0
  localparam int OPND_W  = 13;   // |x| or 2-|x| in the live regions
  localparam int DIFF_W  = 14;   // 2-|x|, up to 2.0
  localparam int SQ_W    = 25;   // square of OPND_W operand, up to 2^24
  localparam int CUBE_W  = 38;   // square times DIFF_W factor
  localparam int MAG_W   = 15;   // slope magnitude, up to 1.0 in Q2.14

  localparam logic [ABS_W-1:0]  ONE_Q12  = ABS_W'(4096);
  localparam logic [ABS_W-1:0]  TWO_Q12  = ABS_W'(8192);
  localparam logic [VAL_W-1:0]  ONE_Q14  = VAL_W'(16384);

endpackage

>>> src/cbk_if.sv
// Valid/ready channel interfaces for the kernel argument and kernel result.
// Depends on cbk_pkg for the field widths.
`timescale 1ns / 1ps

interface cbk_in_if import cbk_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ARG_W-1:0]  arg_x;

  modport source (output valid, output arg_x, input ready);
  modport sink   (input valid, input arg_x, output ready);
endinterface

interface cbk_out_if import cbk_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [VAL_W-1:0]          kernel_value;
  logic signed [SLOPE_W-1:0] kernel_slope;

  modport source (output valid, output kernel_value, output kernel_slope, input ready);
  modport sink   (input valid, input kernel_value, input kernel_slope, output ready);
endinterface

>>> src/cubic_bspline_kernel_core.sv
// Cubic B-spline kernel (peak 1) and its derivative, four-stage pipeline.
// Throughput: one beat per cycle; each stage holds only while the stage after it is full.
// Stages: abs/region, square, cube multiply and slope, final value and sign.
// Reset (rst, synchronous) clears all stage valid bits; data registers are not reset.
// Depends on cbk_pkg and the channel interfaces in cbk_if.sv.
`timescale 1ns / 1ps

module cubic_bspline_kernel_core import cbk_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cbk_in_if.sink    arg,
  cbk_out_if.source kernel
);

  // stage valid bits and enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4 = !v4 || kernel.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign arg.ready = en1;

  // stage 1: magnitude and region
  logic [ABS_W-1:0]  abs_x;
  logic [DIFF_W-1:0] diff;
  logic              is_neg, is_inner, is_outer;
  logic              neg1, inner1;
  logic [OPND_W-1:0] u1;
  logic [DIFF_W-1:0] f1;

  always_comb begin
    is_neg   = arg.arg_x[ARG_W-1];
    abs_x    = is_neg ? ABS_W'(-arg.arg_x) : ABS_W'(arg.arg_x);
    is_inner = abs_x <= ONE_Q12;
    is_outer = !is_inner && (abs_x < TWO_Q12);
    diff     = DIFF_W'(TWO_Q12) - abs_x[DIFF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= arg.valid;
    end
    if (en1) begin
      neg1   <= is_neg;
      inner1 <= is_inner;
      // zero region: operand 0 drives the outer formulas to zero
      u1     <= is_inner ? abs_x[OPND_W-1:0] :
                is_outer ? diff[OPND_W-1:0] : '0;
      f1     <= diff;
    end
  end

  // stage 2: square
  logic              neg2, inner2;
  logic [OPND_W-1:0] u2;
  logic [DIFF_W-1:0] f2;
  logic [SQ_W-1:0]   sq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      neg2   <= neg1;
      inner2 <= inner1;
      u2     <= u1;
      f2     <= inner1 ? f1 : DIFF_W'(u1);
      sq2    <= SQ_W'(SQ_W'(u1) * SQ_W'(u1));
    end
  end

  // stage 3: cube product and slope magnitude
  localparam int N_W = 29;
  logic [N_W-1:0]    n_inner;
  logic [N_W-1:0]    n_outer;
  logic              neg3, inner3;
  logic [CUBE_W-1:0] m3;
  logic [MAG_W-1:0]  mag3;

  always_comb begin
    n_inner = N_W'(u2) * N_W'(49152) - N_W'(sq2) * N_W'(9);
    n_outer = N_W'(sq2) * N_W'(3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      neg3   <= neg2;
      inner3 <= inner2;
      m3     <= CUBE_W'(CUBE_W'(sq2) * CUBE_W'(f2));
      mag3   <= inner2 ? n_inner[MAG_W+11:12] : n_outer[MAG_W+11:12];
    end
  end

  // stage 4: value and signed slope into the output register
  localparam int T_W = CUBE_W + 2;
  logic [T_W-1:0]     t_up;
  logic [VAL_W-1:0]   val_next;
  logic [SLOPE_W-1:0] slope_next;
  logic               inner4;

  always_comb begin
    // round the subtracted term up so the value floors
    t_up       = T_W'(m3) * T_W'(3) + T_W'(24'hFFFFFF);
    val_next   = inner3 ? VAL_W'(ONE_Q14 - VAL_W'(t_up[T_W-1:24]))
                        : VAL_W'(m3[CUBE_W-1:24]);
    slope_next = neg3 ? SLOPE_W'(mag3) : SLOPE_W'(-SLOPE_W'(mag3));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
    if (en4) begin
      inner4              <= inner3;
      kernel.kernel_value <= val_next;
      kernel.kernel_slope <= slope_next;
    end
  end

  assign kernel.valid = v4;

  // checks
  assert property (@(posedge clk) disable iff (rst)
    v4 |-> kernel.kernel_value <= ONE_Q14)
    else $error("kernel value above peak");

  assert property (@(posedge clk) disable iff (rst)
    v4 && kernel.kernel_value == ONE_Q14 |-> kernel.kernel_slope == '0)
    else $error("nonzero slope at kernel peak");

  assert property (@(posedge clk) disable iff (rst)
    v4 && inner4 |-> kernel.kernel_value >= VAL_W'(4096))
    else $error("inner region value below one quarter");

  assert property (@(posedge clk) disable iff (rst)
    v4 && !inner4 |-> kernel.kernel_value < VAL_W'(4096))
    else $error("outer region value at or above one quarter");

endmodule
